// File: hw/rtl/twl_pkg.sv
// ----------------------------------------------------------------------------
// twl_pkg: shared types and constants of the text line wrapper
// Character codes, command and mode codes, and register indexes.
// ----------------------------------------------------------------------------
package twl_pkg;

   localparam int CHAR_BITS = 21;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [CHAR_BITS-1:0] CH_NEWLINE = CHAR_BITS'(10);
   localparam logic [CHAR_BITS-1:0] CH_SPACE   = CHAR_BITS'(32);

   typedef enum logic {
      CMD_CHAR = 1'b0,
      CMD_END  = 1'b1
   } cmd_type;

   // Code 3 is unused and behaves as no wrap.
   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_WIDTH = 2'd1,
      MODE_WORD  = 2'd2
   } mode_type;

   typedef enum logic {
      REG_WRAP_MODE  = 1'b0,
      REG_LINE_WIDTH = 1'b1
   } reg_index_type;

endpackage

// File: hw/rtl/text_line_wrapper.sv
// ----------------------------------------------------------------------------
// text_line_wrapper: greedy word wrap over a character stream
// Characters arrive one request at a time, closed by an end-of-text request.
// Each completed line comes out as one result carrying its start, end, next
// start and length. The block takes one request per clock unless a line
// waits on a stalled output: a request is held in the input register, and
// the line tracking state updates in the same cycle that its result lands
// in the output register. A request that causes no line moves on even
// while a result waits on a stalled output; one that causes a line waits
// until the output register frees. Mode and width are written over the APB
// port at 4*index and must only change while no text is in flight.
// Characters that arrive once the position count reaches its largest value
// are dropped and raise a sticky overflow bit until end of text. Reset is
// synchronous, active high, and needs no clearing pass.
// ----------------------------------------------------------------------------
module text_line_wrapper #(
   parameter int POSITION_BITS = 16,
   parameter int WIDTH_BITS    = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,

   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic [twl_pkg::CHAR_BITS-1:0]         req_char_code,

   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [POSITION_BITS-1:0]              rsp_line_start,
   output logic [POSITION_BITS-1:0]              rsp_line_end,
   output logic [POSITION_BITS-1:0]              rsp_next_start,
   output logic [POSITION_BITS-1:0]              rsp_line_length,
   output logic                                  rsp_text_done,
   output logic                                  rsp_overflow,

   // configuration port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [twl_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [twl_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [twl_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                  pready
);

   import twl_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
   localparam logic [WIDTH_BITS-1:0]    WIDTH_RESET = WIDTH_BITS'(80);

   // --------------------------------------------------------------------------
   // Configuration registers
   // --------------------------------------------------------------------------
   logic [1:0]            wrap_mode_ff;
   logic [WIDTH_BITS-1:0] line_width_ff;
   logic                  csr_write;
   reg_index_type         csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = reg_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_mode_ff  <= MODE_NONE;
         line_width_ff <= WIDTH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_WRAP_MODE:  wrap_mode_ff  <= pwdata[1:0];
            REG_LINE_WIDTH: line_width_ff <= pwdata[WIDTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_WRAP_MODE:  prdata = CSR_DATA_BITS'(wrap_mode_ff);
         REG_LINE_WIDTH: prdata = CSR_DATA_BITS'(line_width_ff);
         default:        prdata = '0;
      endcase
   end

   // --------------------------------------------------------------------------
   // Input register
   // --------------------------------------------------------------------------
   logic                 in_valid_ff;
   logic                 in_cmd_ff;
   logic [CHAR_BITS-1:0] in_char_ff;
   logic                 req_accept;
   logic                 fire;

   // Hold new requests while the registered one would produce a line and the output is full and stalled.
   assign req_stall  = in_valid_ff & ~fire;
   assign req_accept = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff  <= req_cmd;
         in_char_ff <= req_char_code;
      end
   end

   // --------------------------------------------------------------------------
   // Line tracking state
   // --------------------------------------------------------------------------
   logic [POSITION_BITS-1:0] line_begin_ff,     line_begin_in;
   logic [POSITION_BITS-1:0] char_count_ff,     char_count_in;
   logic [WIDTH_BITS-1:0]    used_width_ff,     used_width_in;
   logic [POSITION_BITS-1:0] space_position_ff, space_position_in;
   logic                     space_seen_ff,     space_seen_in;
   logic                     ended_newline_ff,  ended_newline_in;
   logic                     overflow_flag_ff,  overflow_flag_in;

   logic                     res_valid;
   logic [POSITION_BITS-1:0] res_start;
   logic [POSITION_BITS-1:0] res_end;
   logic [POSITION_BITS-1:0] res_next;
   logic                     res_done;

   always_comb begin
      logic [POSITION_BITS-1:0] p;
      logic [POSITION_BITS-1:0] p_next;
      logic [POSITION_BITS-1:0] sp_next;
      logic [WIDTH_BITS-1:0]    used_v;
      logic                     wrapping;
      logic                     word_mode;
      logic                     is_space;

      p         = char_count_ff;
      p_next    = p + POSITION_BITS'(1);
      sp_next   = space_position_ff + POSITION_BITS'(1);
      word_mode = (wrap_mode_ff == MODE_WORD);
      wrapping  = ((wrap_mode_ff == MODE_WIDTH) || word_mode) && (line_width_ff != '0);
      is_space  = (in_char_ff == CH_SPACE);
      used_v    = used_width_ff;

      line_begin_in     = line_begin_ff;
      char_count_in     = char_count_ff;
      used_width_in     = used_width_ff;
      space_position_in = space_position_ff;
      space_seen_in     = space_seen_ff;
      ended_newline_in  = ended_newline_ff;
      overflow_flag_in  = overflow_flag_ff;

      res_valid = 1'b0;
      res_start = '0;
      res_end   = '0;
      res_next  = '0;
      res_done  = 1'b0;

      if (in_cmd_ff == CMD_END) begin
         // Close the open line: empty text, trailing newline or open tail.
         res_done = 1'b1;
         if (p == '0) begin
            res_valid = 1'b1;
         end else if (ended_newline_ff) begin
            res_valid = 1'b1;
            res_start = p;
            res_end   = p;
            res_next  = p;
         end else if (line_begin_ff != p) begin
            res_valid = 1'b1;
            res_start = line_begin_ff;
            res_end   = p;
            res_next  = p;
         end
         line_begin_in     = '0;
         char_count_in     = '0;
         used_width_in     = '0;
         space_position_in = '0;
         space_seen_in     = 1'b0;
         ended_newline_in  = 1'b0;
         overflow_flag_in  = 1'b0;
      end else if (p == POS_MAX) begin
         // Drop the character, flag the overflow.
         overflow_flag_in = 1'b1;
      end else if (in_char_ff == CH_NEWLINE) begin
         res_valid        = 1'b1;
         res_start        = line_begin_ff;
         res_end          = p;
         res_next         = p_next;
         line_begin_in    = p_next;
         used_width_in    = '0;
         space_seen_in    = 1'b0;
         ended_newline_in = 1'b1;
         char_count_in    = p_next;
      end else begin
         ended_newline_in = 1'b0;
         char_count_in    = p_next;
         if (wrapping) begin
            if ((used_width_ff >= line_width_ff) && word_mode && is_space) begin
               // A space right at the limit closes the line and is swallowed.
               res_valid     = 1'b1;
               res_start     = line_begin_ff;
               res_end       = p;
               res_next      = p_next;
               line_begin_in = p_next;
               used_width_in = '0;
               space_seen_in = 1'b0;
            end else begin
               space_seen_in = space_seen_ff;
               if (used_width_ff >= line_width_ff) begin
                  res_valid = 1'b1;
                  res_start = line_begin_ff;
                  if (word_mode && space_seen_ff) begin
                     // Break after the last space; carry the partial word.
                     res_end       = space_position_ff;
                     res_next      = sp_next;
                     line_begin_in = sp_next;
                     used_v        = WIDTH_BITS'(p - sp_next);
                  end else begin
                     // Hard cut before this character.
                     res_end       = p;
                     res_next      = p;
                     line_begin_in = p;
                     used_v        = '0;
                  end
                  space_seen_in = 1'b0;
               end
               if (is_space) begin
                  space_position_in = p;
                  space_seen_in     = 1'b1;
               end
               used_width_in = used_v + WIDTH_BITS'(1);
            end
         end
      end
   end

   // Advance when the request makes no line or the output slot is free.
   assign fire = in_valid_ff & (~res_valid | ~rsp_valid | ~rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_begin_ff     <= '0;
         char_count_ff     <= '0;
         used_width_ff     <= '0;
         space_position_ff <= '0;
         space_seen_ff     <= 1'b0;
         ended_newline_ff  <= 1'b0;
         overflow_flag_ff  <= 1'b0;
      end else if (fire) begin
         line_begin_ff     <= line_begin_in;
         char_count_ff     <= char_count_in;
         used_width_ff     <= used_width_in;
         space_position_ff <= space_position_in;
         space_seen_ff     <= space_seen_in;
         ended_newline_ff  <= ended_newline_in;
         overflow_flag_ff  <= overflow_flag_in;
      end
   end

   // --------------------------------------------------------------------------
   // Result register
   // --------------------------------------------------------------------------
   logic rsp_valid_ff;
   logic rsp_load;

   assign rsp_load  = fire & res_valid;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_line_start  <= res_start;
         rsp_line_end    <= res_end;
         rsp_next_start  <= res_next;
         rsp_line_length <= res_end - res_start;
         rsp_text_done   <= res_done;
         rsp_overflow    <= overflow_flag_ff;
      end
   end

   // --------------------------------------------------------------------------
   // Assertions
   // --------------------------------------------------------------------------
   // The overflow flag only rises once the position counter has saturated.
   a_overflow_saturated: assert property (@(posedge clock) disable iff (reset)
      overflow_flag_ff |-> (char_count_ff == POS_MAX))
      else $error("overflow flag set below the largest position");

   // The open line never begins past the next character position.
   a_begin_order: assert property (@(posedge clock) disable iff (reset)
      line_begin_ff <= char_count_ff)
      else $error("line begin ahead of character count");

   // A line inside the text is ordered start <= end <= next start.
   a_line_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_text_done) |->
         (rsp_line_start <= rsp_line_end) && (rsp_line_end <= rsp_next_start))
      else $error("emitted line positions out of order");

   // A line result can only come from a request that advanced.
   a_load_from_fire: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(fire))
      else $error("result appeared without an advancing request");

endmodule

// File: tb/tb_text_line_wrapper.sv
// ----------------------------------------------------------------------------
// tb_text_line_wrapper: self-checking bench for the text line wrapper
// Streams whole texts (characters closed by an end-of-text request) under
// every wrap mode and a spread of widths. A line tracker predicts each
// emitted line and checks the results in order. The bench runs a directed
// opener and then random texts under four idling profiles.
// ----------------------------------------------------------------------------
module tb_text_line_wrapper;
   import twl_pkg::*;

   localparam int POS_BITS   = 16;
   localparam int WID_BITS   = 12;
   localparam int QUIET_LIMIT = 4000;
   localparam int BLOCK_ITEMS = 112;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [CHAR_BITS-1:0] CH_A = CHAR_BITS'(97);

   typedef struct packed {
      logic [POS_BITS-1:0] line_start;
      logic [POS_BITS-1:0] line_end;
      logic [POS_BITS-1:0] next_start;
      logic [POS_BITS-1:0] line_length;
      logic                text_done;
      logic                overflow;
   } wrapped_line_type;

   // Line tracker: mirrors the wrapper state and holds the lines still owed.
   class line_tracker_type;
      logic [1:0]          mode;
      logic [WID_BITS-1:0] width;
      logic [POS_BITS-1:0] line_begin;
      logic [POS_BITS-1:0] char_count;
      logic [POS_BITS-1:0] space_pos;
      logic [WID_BITS-1:0] used;
      bit                  space_seen;
      bit                  ended_newline;
      bit                  overflow_flag;
      wrapped_line_type    pending[$];
      int                  errors;

      function new();
         mode   = MODE_NONE;
         width  = WID_BITS'(80);
         errors = 0;
         clear_text();
      endfunction

      function void clear_text();
         line_begin    = '0;
         char_count    = '0;
         space_pos     = '0;
         used          = '0;
         space_seen    = 1'b0;
         ended_newline = 1'b0;
         overflow_flag = 1'b0;
      endfunction

      function void set_reg(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         if (idx == REG_WRAP_MODE) begin
            mode = value[1:0];
         end else begin
            width = value[WID_BITS-1:0];
         end
      endfunction

      function void push_line(logic [POS_BITS-1:0] s, logic [POS_BITS-1:0] e,
                              logic [POS_BITS-1:0] n, bit done);
         wrapped_line_type ln;
         ln.line_start  = s;
         ln.line_end    = e;
         ln.next_start  = n;
         ln.line_length = e - s;
         ln.text_done   = done;
         ln.overflow    = overflow_flag;
         pending.insert(pending.size(), ln);
      endfunction

      function void take_request(cmd_type cmd, logic [CHAR_BITS-1:0] code);
         logic [POS_BITS-1:0] p;
         bit wrapping;
         wrapping = (mode == MODE_WIDTH || mode == MODE_WORD) && width != '0;
         p = char_count;
         if (cmd == CMD_END) begin
            if (char_count == '0) begin
               push_line('0, '0, '0, 1'b1);
            end else if (ended_newline) begin
               push_line(char_count, char_count, char_count, 1'b1);
            end else if (line_begin != char_count) begin
               push_line(line_begin, char_count, char_count, 1'b1);
            end
            clear_text();
            return;
         end
         if (p == '1) begin
            overflow_flag = 1'b1;
            return;
         end
         if (code == CH_NEWLINE) begin
            push_line(line_begin, p, p + 1'b1, 1'b0);
            line_begin    = p + 1'b1;
            used          = '0;
            space_seen    = 1'b0;
            ended_newline = 1'b1;
            char_count    = p + 1'b1;
            return;
         end
         ended_newline = 1'b0;
         char_count    = p + 1'b1;
         if (!wrapping) return;
         if (used >= width) begin
            if (mode == MODE_WORD && code == CH_SPACE) begin
               push_line(line_begin, p, p + 1'b1, 1'b0);
               line_begin = p + 1'b1;
               used       = '0;
               space_seen = 1'b0;
               return;
            end
            if (mode == MODE_WORD && space_seen) begin
               push_line(line_begin, space_pos, space_pos + 1'b1, 1'b0);
               line_begin = space_pos + 1'b1;
               used       = WID_BITS'(p - line_begin);
            end else begin
               push_line(line_begin, p, p, 1'b0);
               line_begin = p;
               used       = '0;
            end
            space_seen = 1'b0;
         end
         if (code == CH_SPACE) begin
            space_pos  = p;
            space_seen = 1'b1;
         end
         used = used + 1'b1;
      endfunction

      function void compare(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_line(wrapped_line_type got);
         wrapped_line_type want;
         if (pending.size() == 0) begin
            $error("line result with none owed: start %0d end %0d",
                   got.line_start, got.line_end);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare("line_start", want.line_start, got.line_start);
         compare("line_end", want.line_end, got.line_end);
         compare("next_start", want.next_start, got.next_start);
         compare("line_length", want.line_length, got.line_length);
         compare("text_done", want.text_done, got.text_done);
         compare("overflow", want.overflow, got.overflow);
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Block signals; every input starts at a known value
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid     = 1'b0;
   logic                 req_stall;
   logic                 req_cmd       = CMD_CHAR;
   logic [CHAR_BITS-1:0] req_char_code = '0;

   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [POS_BITS-1:0] rsp_line_start;
   logic [POS_BITS-1:0] rsp_line_end;
   logic [POS_BITS-1:0] rsp_next_start;
   logic [POS_BITS-1:0] rsp_line_length;
   logic                rsp_text_done;
   logic                rsp_overflow;

   logic                     psel    = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr   = '0;
   logic [CSR_DATA_BITS-1:0] pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   line_tracker_type tracker;
   wrapped_line_type got_line;
   int            gap_pct   = 0;   // chance per cycle that the sender idles
   int            stall_pct = 0;   // chance per cycle that the receiver stalls
   int            sent_count = 0;
   int            quiet_cycles = 0;

   text_line_wrapper #(
      .POSITION_BITS (POS_BITS),
      .WIDTH_BITS    (WID_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_char_code   (req_char_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_line_start  (rsp_line_start),
      .rsp_line_end    (rsp_line_end),
      .rsp_next_start  (rsp_next_start),
      .rsp_line_length (rsp_line_length),
      .rsp_text_done   (rsp_text_done),
      .rsp_overflow    (rsp_overflow),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Result side: check each accepted line, randomize stall, run the watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      // Sample the pre-edge values, so the check sees what the block saw.
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got_line.line_start  = rsp_line_start;
            got_line.line_end    = rsp_line_end;
            got_line.next_start  = rsp_next_start;
            got_line.line_length = rsp_line_length;
            got_line.text_done   = rsp_text_done;
            got_line.overflow    = rsp_overflow;
            tracker.check_line(got_line);
         end
         // Restart the quiet count on any handshake on either channel.
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offer one request, idling first as the profile says, and hold it until
   // accepted. Valid stays high afterwards; the next caller moves it.
   task automatic send_request(cmd_type cmd, logic [CHAR_BITS-1:0] code);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_char_code <= code;
      do @(posedge clock); while (req_stall);
      tracker.take_request(cmd, code);
      sent_count++;
   endtask

   // Drop valid, wait for every owed line, then let the pipe settle. A
   // request that makes no line can still be in flight, so always wait out
   // the settle count past the last result.
   task automatic drain(int settle);
      req_valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // APB write, then read back the same register back to back.
   task automatic write_reg(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] stored;
      stored = (idx == REG_WRAP_MODE) ? (value & 32'h3) : (value & 32'hFFF);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_BITS'(int'(idx) * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tracker.set_reg(idx, value);
      // Go straight into the setup cycle of the read.
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== stored) begin
         $error("register %0d: expected %0d, got %0d", int'(idx), stored, prdata);
         tracker.errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly letters and spaces, some newlines, and a little raw noise that
   // reaches every bit of the character field.
   function automatic logic [CHAR_BITS-1:0] pick_char();
      int r;
      r = $urandom_range(99);
      if (r < 22) return CH_SPACE;
      if (r < 28) return CH_NEWLINE;
      if (r < 33) return CHAR_BITS'($urandom);
      return CH_A + CHAR_BITS'($urandom_range(25));
   endfunction

   // One whole text, always closed by an end-of-text request.
   task automatic send_text();
      int len;
      case ($urandom_range(9))
         0:       len = 0;
         1:       len = $urandom_range(40, 80);
         default: len = $urandom_range(1, 20);
      endcase
      repeat (len) send_request(CMD_CHAR, pick_char());
      send_request(CMD_END, CHAR_BITS'($urandom));
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [1:0]          mode;
      logic [WID_BITS-1:0] width;
      int                  block_start;

      tracker = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings, no wrap: empty text, then a trailing newline.
      send_request(CMD_END, '0);
      send_request(CMD_CHAR, '0);
      send_request(CMD_CHAR, CH_NEWLINE);
      send_request(CMD_END, '1);

      // Whole words at width 2: the closing space breaks the line, so
      // end of text owes nothing.
      drain(4);
      write_reg(REG_WRAP_MODE, MODE_WORD);
      write_reg(REG_LINE_WIDTH, 2);
      send_request(CMD_CHAR, CH_A);
      send_request(CMD_CHAR, CH_A + 1'b1);
      send_request(CMD_CHAR, CH_SPACE);
      send_request(CMD_END, '0);

      // Whole words at width 3: break back at the last space.
      drain(4);
      write_reg(REG_LINE_WIDTH, 3);
      send_request(CMD_CHAR, CH_A);
      send_request(CMD_CHAR, CH_A + 1'b1);
      send_request(CMD_CHAR, CH_SPACE);
      send_request(CMD_CHAR, CH_A + 2'd2);
      send_request(CMD_CHAR, CH_A + 2'd3);
      send_request(CMD_END, '0);

      // Hard break at width 1 with the largest character codes.
      drain(4);
      write_reg(REG_WRAP_MODE, MODE_WIDTH);
      write_reg(REG_LINE_WIDTH, 1);
      send_request(CMD_CHAR, CHAR_BITS'(1114111));
      send_request(CMD_CHAR, '1);
      send_request(CMD_END, '0);

      // Unused mode code behaves as no wrap.
      drain(4);
      write_reg(REG_WRAP_MODE, MODE_UNUSED);
      send_request(CMD_CHAR, CH_A);
      send_request(CMD_CHAR, CH_A);
      send_request(CMD_END, '0);

      // Zero width behaves as no wrap.
      drain(4);
      write_reg(REG_WRAP_MODE, MODE_WIDTH);
      write_reg(REG_LINE_WIDTH, 0);
      send_request(CMD_CHAR, CH_A);
      send_request(CMD_CHAR, CH_A);
      send_request(CMD_END, '0);

      // Widest line.
      drain(4);
      write_reg(REG_LINE_WIDTH, 4095);
      send_request(CMD_CHAR, CH_A);
      send_request(CMD_END, '0);

      // Random texts: four idling profiles, four settings each.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 61; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 61; end
            default: begin gap_pct = 9; stall_pct = 9; end
         endcase
         for (int k = 0; k < 4; k++) begin
            case (k)
               0:       mode = 2'($urandom_range(3));
               1:       mode = MODE_WIDTH;
               default: mode = MODE_WORD;
            endcase
            case ($urandom_range(9))
               0:       width = '0;
               1:       width = WID_BITS'(1);
               2:       width = '1;
               default: width = WID_BITS'($urandom_range(2, 12));
            endcase
            drain(4);
            write_reg(REG_WRAP_MODE, mode);
            write_reg(REG_LINE_WIDTH, width);
            block_start = sent_count;
            while (sent_count - block_start < BLOCK_ITEMS) begin
               // Now and then hold off until every owed line is out.
               if ($urandom_range(19) == 0) drain(2);
               send_text();
            end
         end
      end

      drain(12);
      if (tracker.errors == 0 && tracker.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
